[rtl/core/grm_pkg.sv]
package grm_pkg;

	// Grid geometry
	localparam int GRID_ROWS = 20;
	localparam int GRID_COLS = 20;
	localparam int ROW_BITS  = 20;
	localparam int ROW_AW    = $clog2(GRID_ROWS);
	localparam int IDX_W     = 5;

	// Field and datapath widths
	localparam int CELL_W     = 8;
	localparam int STEP_W     = 10;
	localparam int COORD_W    = 10;
	localparam int HEAD_W     = 15;
	localparam int POS_W      = 12;
	localparam int TRIG_W     = 17;
	localparam int ACC_W      = 26;
	localparam int ANG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Angles in sixteenths of a degree
	localparam logic signed [15:0] TURN      = 16'sd5760;
	localparam logic [ANG_W-1:0]   QUARTER   = 11'd1440;
	localparam logic [12:0]        ANG_Q1    = 13'd1440;
	localparam logic [12:0]        ANG_Q2    = 13'd2880;
	localparam logic [12:0]        ANG_Q3    = 13'd4320;

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 2'd2;
	localparam logic [CELL_W-1:0]    CELL_WIDTH_RST  = 8'd30;
	localparam logic [CELL_W-1:0]    CELL_HEIGHT_RST = 8'd30;
	localparam logic [STEP_W-1:0]    MAX_STEPS_RST   = 10'd600;

	typedef logic [TRIG_W-1:0] sin_tab_t [0:1440];

	typedef struct packed {
		logic signed [POS_W-1:0] q;
		logic [CELL_W-1:0]       r;
	} grm_axis_t;

	typedef struct packed {
		logic grid_wr;
		logic cap;
		logic rom_cos;
		logic ld_sin;
		logic ld_cos;
		logic div_start;
		logic div_sel_y;
		logic ld_divx;
		logic ld_divy;
		logic step;
		logic ld_res;
		logic res_hit;
		logic ld_out;
	} grm_cmd_t;

	typedef struct packed {
		logic ang_ok;
		logic div_done;
		logic can_step;
		logic hit;
		logic pipe_busy;
		logic out_free;
	} grm_stat_t;

	// Q1.16 sine of a sixteenth-degree angle, rounded to nearest, by a Taylor series in Q2.30.
	function automatic logic [TRIG_W-1:0] sine_q16(input int a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		x    = (64'(a) * 64'd3373259426 + 64'd1440) / 64'd2880;
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
		v = (sum + 64'd8192) >> 14;
		if (v > 64'd65536) begin
			v = 64'd65536;
		end
		return v[TRIG_W-1:0];
	endfunction

	function automatic sin_tab_t build_sin_tab();
		sin_tab_t t;
		for (int i = 0; i <= 1440; i++) begin
			t[i] = sine_q16(i);
		end
		return t;
	endfunction

	localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

[rtl/core/grm_div.sv]
module grm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grm_pkg::COORD_W-1:0]  dividend,
	input  logic [grm_pkg::CELL_W-1:0]   divisor,
	output logic                         done,
	output logic [grm_pkg::COORD_W-1:0]  quo,
	output logic [grm_pkg::CELL_W-1:0]   rem
);
	import grm_pkg::*;

	localparam int CNT_W = $clog2(COORD_W + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [COORD_W-1:0]  quo_q;
	logic [CELL_W-1:0]   rem_q;
	logic [CELL_W-1:0]   dvs_q;
	logic [CELL_W:0]     partial;
	logic [CELL_W:0]     diff;
	logic                fits;

	// One quotient bit per cycle, restoring form.
	assign partial = {rem_q, quo_q[COORD_W-1]};
	assign fits    = partial >= {1'b0, dvs_q};
	assign diff    = partial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(COORD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[CELL_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], 1'b1};
			end else begin
				rem_q <= partial[CELL_W-1:0];
				quo_q <= {quo_q[COORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/core/grm_dp.sv]
module grm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  grm_pkg::grm_cmd_t              ctl,
	output grm_pkg::grm_stat_t             st,
	input  logic                           cfg_valid,
	input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [4:0]                     row_index,
	input  logic [grm_pkg::ROW_BITS-1:0]   row_bits,
	input  logic [grm_pkg::COORD_W-1:0]    origin_x,
	input  logic [grm_pkg::COORD_W-1:0]    origin_y,
	input  logic signed [grm_pkg::HEAD_W-1:0] heading,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [grm_pkg::STEP_W-1:0]     distance,
	output logic                           hit,
	output logic [grm_pkg::IDX_W-1:0]      hit_col,
	output logic [grm_pkg::IDX_W-1:0]      hit_row
);
	import grm_pkg::*;

	// Configuration
	logic [CELL_W-1:0] cell_width_q;
	logic [CELL_W-1:0] cell_height_q;
	logic [STEP_W-1:0] max_steps_q;
	logic [CELL_W-1:0] w_eff;
	logic [CELL_W-1:0] ht_eff;

	// Cast setup
	logic signed [15:0] h0;
	logic signed [15:0] h1;
	logic signed [15:0] h2;
	logic               ang_ok;
	logic [12:0]        hu;
	logic [1:0]         quad;
	logic [12:0]        base;
	logic [12:0]        a_full;
	logic               ang_ok_q;
	logic [1:0]         q_q;
	logic [ANG_W-1:0]   a_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [ANG_W-1:0]   rom_addr;
	logic [TRIG_W-1:0]  rom_q;
	logic [TRIG_W-1:0]  sin_q;
	logic [TRIG_W-1:0]  cos_q;

	// Divider
	logic               div_done;
	logic [COORD_W-1:0] div_quo;
	logic [CELL_W-1:0]  div_rem;

	// Stepper
	logic [STEP_W-1:0]  m_q;
	logic [ACC_W-1:0]   acc_s_q;
	logic [ACC_W-1:0]   acc_c_q;
	logic [ACC_W-1:0]   acc_s_n;
	logic [ACC_W-1:0]   acc_c_n;
	logic               ds;
	logic               dc;
	logic               mvx;
	logic               mvy;
	logic               posx;
	logic               posy;
	grm_axis_t          ax_x_q;
	grm_axis_t          ax_y_q;
	logic               st_new_q;

	// Cell selection
	logic                    left;
	logic                    up;
	logic signed [POS_W-1:0] v_col_raw;
	logic signed [POS_W-1:0] h_row_raw;
	logic [IDX_W-1:0]        v_col_c;
	logic [IDX_W-1:0]        v_row_c;
	logic [IDX_W-1:0]        h_col_c;
	logic [IDX_W-1:0]        h_row_c;
	logic                    v_out;
	logic                    h_out;

	logic [ROW_BITS-1:0] grid_q [0:GRID_ROWS-1];

	// Test stage
	logic                s1_valid;
	logic [STEP_W-1:0]   m_s1;
	logic                v_on_s1;
	logic                h_on_s1;
	logic                v_out_s1;
	logic                h_out_s1;
	logic [IDX_W-1:0]    v_col_s1;
	logic [IDX_W-1:0]    v_row_s1;
	logic [IDX_W-1:0]    h_col_s1;
	logic [IDX_W-1:0]    h_row_s1;
	logic [ROW_BITS-1:0] v_data_s1;
	logic [ROW_BITS-1:0] h_data_s1;
	logic                v_bit;
	logic                h_bit;
	logic                v_wall;
	logic                h_wall;

	// Result
	logic [STEP_W-1:0] res_dist_q;
	logic              res_hit_q;
	logic [IDX_W-1:0]  res_col_q;
	logic [IDX_W-1:0]  res_row_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] out_dist_q;
	logic              out_hit_q;
	logic [IDX_W-1:0]  out_col_q;
	logic [IDX_W-1:0]  out_row_q;

	function automatic grm_axis_t axis_step(input grm_axis_t cur, input logic mv,
			input logic pos, input logic [CELL_W-1:0] lim_m1);
		grm_axis_t nxt;
		nxt = cur;
		if (mv) begin
			if (pos) begin
				if (cur.r == lim_m1) begin
					nxt.r = '0;
					nxt.q = cur.q + POS_W'(1);
				end else begin
					nxt.r = cur.r + CELL_W'(1);
				end
			end else begin
				if (cur.r == '0) begin
					nxt.r = lim_m1;
					nxt.q = cur.q - POS_W'(1);
				end else begin
					nxt.r = cur.r - CELL_W'(1);
				end
			end
		end
		return nxt;
	endfunction

	function automatic logic is_outside(input logic signed [POS_W-1:0] v, input int lim);
		return (v < 0) || (v >= lim);
	endfunction

	function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [POS_W-1:0] v,
			input int lim);
		logic [IDX_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v >= lim) begin
			r = IDX_W'(lim - 1);
		end else begin
			r = v[IDX_W-1:0];
		end
		return r;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_width_q  <= CELL_WIDTH_RST;
			cell_height_q <= CELL_HEIGHT_RST;
			max_steps_q   <= MAX_STEPS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CELL_WIDTH:  cell_width_q  <= cfg_data[CELL_W-1:0];
				CFG_CELL_HEIGHT: cell_height_q <= cfg_data[CELL_W-1:0];
				CFG_MAX_STEPS:   max_steps_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff  = (cell_width_q == '0) ? CELL_W'(1) : cell_width_q;
	assign ht_eff = (cell_height_q == '0) ? CELL_W'(1) : cell_height_q;

	// Heading folded once into one turn, then split into quadrant and angle within it.
	always_comb begin
		h0     = {heading[HEAD_W-1], heading};
		h1     = (h0 > TURN) ? h0 - TURN : h0;
		h2     = (h1 < 16'sd0) ? h1 + TURN : h1;
		ang_ok = (h2 >= 16'sd0) && (h2 < TURN);
		hu     = h2[12:0];
		if (hu < ANG_Q1) begin
			quad = 2'd0;
			base = '0;
		end else if (hu < ANG_Q2) begin
			quad = 2'd1;
			base = ANG_Q1;
		end else if (hu < ANG_Q3) begin
			quad = 2'd2;
			base = ANG_Q2;
		end else begin
			quad = 2'd3;
			base = ANG_Q3;
		end
		a_full = hu - base;
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			ang_ok_q <= ang_ok;
			q_q      <= quad;
			a_q      <= a_full[ANG_W-1:0];
			x_q      <= origin_x;
			y_q      <= origin_y;
		end
	end

	// Sine table, one registered read per cycle; cosine is the sine of the complement.
	assign rom_addr = ctl.rom_cos ? QUARTER - a_q : a_q;

	always_ff @(posedge clk) begin
		rom_q <= SIN_TAB[rom_addr];
		if (ctl.ld_sin) begin
			sin_q <= rom_q;
		end
		if (ctl.ld_cos) begin
			cos_q <= rom_q;
		end
	end

	grm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (ctl.div_sel_y ? y_q : x_q),
		.divisor  (ctl.div_sel_y ? ht_eff : w_eff),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Each step moves the offsets by at most one pixel per axis, so the cell index
	// and the remainder within the cell are tracked incrementally.
	assign acc_s_n = acc_s_q + ACC_W'(sin_q);
	assign acc_c_n = acc_c_q + ACC_W'(cos_q);
	assign ds      = acc_s_n[ACC_W-1:16] != acc_s_q[ACC_W-1:16];
	assign dc      = acc_c_n[ACC_W-1:16] != acc_c_q[ACC_W-1:16];
	assign mvx     = q_q[0] ? ds : dc;
	assign mvy     = q_q[0] ? dc : ds;
	assign posx    = q_q[1] == q_q[0];
	assign posy    = q_q[1];

	always_ff @(posedge clk) begin
		if (ctl.ld_divx) begin
			ax_x_q.q <= $signed({{(POS_W-COORD_W){1'b0}}, div_quo});
			ax_x_q.r <= div_rem;
		end else if (ctl.step) begin
			ax_x_q <= axis_step(ax_x_q, mvx, posx, w_eff - CELL_W'(1));
		end
		if (ctl.ld_divy) begin
			ax_y_q.q <= $signed({{(POS_W-COORD_W){1'b0}}, div_quo});
			ax_y_q.r <= div_rem;
			m_q      <= '0;
			acc_s_q  <= '0;
			acc_c_q  <= '0;
		end else if (ctl.step) begin
			ax_y_q  <= axis_step(ax_y_q, mvy, posy, ht_eff - CELL_W'(1));
			m_q     <= m_q + STEP_W'(1);
			acc_s_q <= acc_s_n;
			acc_c_q <= acc_c_n;
		end
	end

	// Cells beyond the vertical and the horizontal cell line of the current point.
	always_comb begin
		left      = q_q[1] ^ q_q[0];
		up        = !q_q[1];
		v_col_raw = ax_x_q.q - POS_W'(left);
		h_row_raw = ax_y_q.q - POS_W'(up);
		v_out     = is_outside(ax_y_q.q, GRID_ROWS) || is_outside(v_col_raw, GRID_COLS);
		h_out     = is_outside(h_row_raw, GRID_ROWS) || is_outside(ax_x_q.q, GRID_COLS);
		v_col_c   = clamp_idx(v_col_raw, GRID_COLS);
		v_row_c   = clamp_idx(ax_y_q.q, GRID_ROWS);
		h_col_c   = clamp_idx(ax_x_q.q, GRID_COLS);
		h_row_c   = clamp_idx(h_row_raw, GRID_ROWS);
	end

	// Grid store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (ctl.grid_wr && (row_index < GRID_ROWS)) begin
			grid_q[row_index[ROW_AW-1:0]] <= row_bits;
		end
		v_data_s1 <= grid_q[v_row_c[ROW_AW-1:0]];
		h_data_s1 <= grid_q[h_row_c[ROW_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_new_q <= 1'b0;
			s1_valid <= 1'b0;
		end else begin
			st_new_q <= ctl.step;
			s1_valid <= st_new_q;
		end
	end

	always_ff @(posedge clk) begin
		m_s1     <= m_q;
		v_on_s1  <= ax_x_q.r == '0;
		h_on_s1  <= ax_y_q.r == '0;
		v_out_s1 <= v_out;
		h_out_s1 <= h_out;
		v_col_s1 <= v_col_c;
		v_row_s1 <= v_row_c;
		h_col_s1 <= h_col_c;
		h_row_s1 <= h_row_c;
	end

	// The vertical line test takes precedence within one step.
	assign v_bit  = (v_col_s1 < ROW_BITS) && v_data_s1[v_col_s1];
	assign h_bit  = (h_col_s1 < ROW_BITS) && h_data_s1[h_col_s1];
	assign v_wall = v_on_s1 && (v_out_s1 || v_bit);
	assign h_wall = h_on_s1 && (h_out_s1 || h_bit);

	always_ff @(posedge clk) begin
		if (ctl.ld_res) begin
			if (ctl.res_hit) begin
				res_dist_q <= m_s1;
				res_hit_q  <= 1'b1;
				res_col_q  <= v_wall ? v_col_s1 : h_col_s1;
				res_row_q  <= v_wall ? v_row_s1 : h_row_s1;
			end else begin
				res_dist_q <= '0;
				res_hit_q  <= 1'b0;
				res_col_q  <= '0;
				res_row_q  <= '0;
			end
		end
		if (ctl.ld_out) begin
			out_dist_q <= res_dist_q;
			out_hit_q  <= res_hit_q;
			out_col_q  <= res_col_q;
			out_row_q  <= res_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign st.ang_ok    = ang_ok_q;
	assign st.div_done  = div_done;
	assign st.can_step  = ({1'b0, m_q} + (STEP_W+1)'(1)) < {1'b0, max_steps_q};
	assign st.hit       = s1_valid && (v_wall || h_wall);
	assign st.pipe_busy = st_new_q || s1_valid;
	assign st.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign distance  = out_dist_q;
	assign hit       = out_hit_q;
	assign hit_col   = out_col_q;
	assign hit_row   = out_row_q;

endmodule

[rtl/core/grm_ctrl.sv]
module grm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	output logic               in_ready,
	input  grm_pkg::grm_stat_t st,
	output grm_pkg::grm_cmd_t  ctl
);
	import grm_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SIN   = 4'd1;
	localparam logic [3:0] ST_COS   = 4'd2;
	localparam logic [3:0] ST_DIVX  = 4'd3;
	localparam logic [3:0] ST_WAITX = 4'd4;
	localparam logic [3:0] ST_DIVY  = 4'd5;
	localparam logic [3:0] ST_WAITY = 4'd6;
	localparam logic [3:0] ST_MARCH = 4'd7;
	localparam logic [3:0] ST_DRAIN = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd) begin
						ctl.cap = 1'b1;
						state_d = ST_SIN;
					end else begin
						ctl.grid_wr = 1'b1;
					end
				end
			end
			ST_SIN: begin
				if (!st.ang_ok) begin
					ctl.ld_res = 1'b1;
					state_d    = ST_FIN;
				end else begin
					state_d = ST_COS;
				end
			end
			ST_COS: begin
				ctl.rom_cos = 1'b1;
				ctl.ld_sin  = 1'b1;
				state_d     = ST_DIVX;
			end
			ST_DIVX: begin
				ctl.ld_cos    = 1'b1;
				ctl.div_start = 1'b1;
				state_d       = ST_WAITX;
			end
			ST_WAITX: begin
				if (st.div_done) begin
					ctl.ld_divx = 1'b1;
					state_d     = ST_DIVY;
				end
			end
			ST_DIVY: begin
				ctl.div_start = 1'b1;
				ctl.div_sel_y = 1'b1;
				state_d       = ST_WAITY;
			end
			ST_WAITY: begin
				if (st.div_done) begin
					ctl.ld_divy = 1'b1;
					state_d     = ST_MARCH;
				end
			end
			ST_MARCH: begin
				if (st.hit) begin
					ctl.ld_res  = 1'b1;
					ctl.res_hit = 1'b1;
					state_d     = ST_FIN;
				end else if (st.can_step) begin
					ctl.step = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// Steps already issued are still being tested.
				if (st.hit) begin
					ctl.ld_res  = 1'b1;
					ctl.res_hit = 1'b1;
					state_d     = ST_FIN;
				end else if (!st.pipe_busy) begin
					ctl.ld_res = 1'b1;
					state_d    = ST_FIN;
				end
			end
			ST_FIN: begin
				if (st.out_free) begin
					ctl.ld_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_res_then_fin: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_res |=> state_q == ST_FIN)
		else $error("result latched without moving to the finish state");

	a_div_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == ST_WAITX || state_q == ST_WAITY))
		else $error("divider finished while no division was awaited");

	a_hit_in_march: assert property (@(posedge clk) disable iff (!arst_n)
		st.hit |-> (state_q == ST_MARCH || state_q == ST_DRAIN || state_q == ST_FIN))
		else $error("wall test reported outside a march");

	a_step_then_march: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |=> (state_q == ST_MARCH || state_q == ST_FIN))
		else $error("march left without draining the step pipeline");

endmodule

[rtl/core/grid_ray_march.sv]
// Ray caster over a stored occupancy grid of 20 by 20 cells.
// Input channel (in_valid/in_ready): a word with cmd 0 loads one grid row of
// wall bits and gives no result. A word with cmd 1 casts a
// ray from (origin_x, origin_y) at the given heading and gives one result word.
// Output channel (out_valid/out_ready): distance, hit, hit_col and hit_row.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 is
// cell_width, 1 is cell_height, 2 is max_steps; write only while no cast is open.
// A cast whose heading folds into one turn reads the sine and the cosine from
// the table and divides origin_x by cell_width and origin_y by cell_height,
// then marches step by step until the wall test reports a hit or max_steps is
// reached, in which case it drains the steps still in the wall test.
// One cast is processed at a time; the step counter sets the throughput.
// The result sits in an output register, so a stalled receiver does not block
// row loads, and a new cast is taken while the previous result still waits;
// that cast then holds in its last state until the register is free.
// Reset restores the configuration defaults and empties both channels. Grid
// rows are undefined until loaded.
module grid_ray_march (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [4:0]                     row_index,
	input  logic [grm_pkg::ROW_BITS-1:0]   row_bits,
	input  logic [grm_pkg::COORD_W-1:0]    origin_x,
	input  logic [grm_pkg::COORD_W-1:0]    origin_y,
	input  logic signed [grm_pkg::HEAD_W-1:0] heading,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [grm_pkg::STEP_W-1:0]     distance,
	output logic                           hit,
	output logic [grm_pkg::IDX_W-1:0]      hit_col,
	output logic [grm_pkg::IDX_W-1:0]      hit_row,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [grm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import grm_pkg::*;

	grm_cmd_t  ctl;
	grm_stat_t st;

	assign cfg_ready = 1'b1;

	grm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	grm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.st        (st),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row_index (row_index),
		.row_bits  (row_bits),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.heading   (heading),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.distance  (distance),
		.hit       (hit),
		.hit_col   (hit_col),
		.hit_row   (hit_row)
	);

endmodule
